### hw/rtl/sled_pkg.sv
// Shared types, character codes and decode mode codes for the string literal
// escape decoder. No dependencies; imported by string_literal_escape_decoder.

package sled_pkg;

	// Result kinds
	localparam logic [1:0] KIND_BYTE    = 2'd0;
	localparam logic [1:0] KIND_DONE    = 2'd1;
	localparam logic [1:0] KIND_UNTERM  = 2'd2;

	// Decode modes
	localparam int unsigned MODE_W = 3;
	localparam logic [MODE_W-1:0] MODE_NORMAL = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ESC    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_HEX1   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_HEX2   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_OCT2   = 3'd4;
	localparam logic [MODE_W-1:0] MODE_OCT3   = 3'd5;

	// Character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LB    = 8'h62;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_LN    = 8'h6E;
	localparam logic [7:0] CH_LR    = 8'h72;
	localparam logic [7:0] CH_LT    = 8'h74;
	localparam logic [7:0] CH_LV    = 8'h76;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;

	// One result item
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       last;
	} result_t;

	// Value of a hex digit; anything that is not a hex digit counts as zero.
	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			v = c[3:0];
		end else if ((c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF)) begin
			v = c[3:0] + 4'd9;
		end
		return v;
	endfunction

endpackage

### hw/rtl/string_literal_escape_decoder.sv
// String literal escape decoder: input register, escape decode logic and a
// two-entry result buffer. Depends on sled_pkg.
//
// A character taken into the input register is decoded there against the current
// mode, and its results are written into the result buffer that drives the port.
// Throughput: one character per cycle while the buffer has room. A character that
// gives two results holds the result port until both are taken; the input stalls
// only when the buffer, after any pop, cannot take all results of the character
// in the input register.
// Reset clears the decode mode, the partial value and all valid state.

module string_literal_escape_decoder (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  char_valid,
	output logic                  char_stall,
	input  logic [7:0]            char_in,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [1:0]            result_kind,
	output logic [7:0]            out_byte,
	output logic                  last_of_run
);
	import sled_pkg::*;

	logic                valid_s1;
	logic [7:0]          char_s1;
	logic [MODE_W-1:0]   mode_q;
	logic [7:0]          partial_q;
	logic [1:0]          count_q;
	result_t             entry_q [0:1];

	logic [MODE_W-1:0]   mode_nxt;
	logic [7:0]          partial_nxt;
	logic [1:0]          n_res;
	result_t             res0;
	result_t             res1;
	logic [7:0]          w;
	logic [3:0]          hv;
	logic                pop;
	logic [1:0]          base_cnt;
	logic                fire_s1;
	result_t             entry_nxt [0:1];
	logic [1:0]          count_nxt;

	// Input register: loads whenever the decode stage is free or moving on.
	assign char_stall = valid_s1 && !fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!char_stall) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!char_stall && char_valid) begin
			char_s1 <= char_in;
		end
	end

	// Escape decode of the registered character against the current mode.
	always_comb begin
		w           = char_s1 - CH_ZERO;
		hv          = hex_value(char_s1);
		mode_nxt    = mode_q;
		partial_nxt = partial_q;
		n_res       = 2'd0;
		res0        = '{kind: KIND_BYTE, data: char_s1, last: 1'b1};
		res1        = '{kind: KIND_BYTE, data: char_s1, last: 1'b1};
		if (char_s1 == CH_NUL) begin
			mode_nxt    = MODE_NORMAL;
			partial_nxt = 8'd0;
			n_res       = 2'd1;
			res0        = '{kind: KIND_UNTERM, data: 8'd0, last: 1'b1};
		end else begin
			case (mode_q)
				MODE_ESC: begin
					mode_nxt = MODE_NORMAL;
					n_res    = 2'd1;
					case (char_s1)
						CH_QUOTE: res0.data = CH_QUOTE;
						CH_BSL:   res0.data = CH_BSL;
						CH_LA:    res0.data = 8'd7;
						CH_LB:    res0.data = 8'd8;
						CH_LT:    res0.data = 8'd9;
						CH_LN:    res0.data = 8'd10;
						CH_LV:    res0.data = 8'd11;
						CH_LF:    res0.data = 8'd12;
						CH_LR:    res0.data = 8'd13;
						CH_LX: begin
							mode_nxt    = MODE_HEX1;
							partial_nxt = 8'd0;
							n_res       = 2'd0;
						end
						default: begin
							if (char_s1 >= CH_ZERO && char_s1 <= CH_NINE) begin
								partial_nxt = {w[1:0], 6'd0};
								mode_nxt    = MODE_OCT2;
								n_res       = 2'd0;
							end else begin
								// Unknown escape: the backslash, then the character.
								n_res = 2'd2;
								res0  = '{kind: KIND_BYTE, data: CH_BSL, last: 1'b0};
							end
						end
					endcase
				end
				MODE_HEX1: begin
					partial_nxt = {hv, 4'd0};
					mode_nxt    = MODE_HEX2;
				end
				MODE_HEX2: begin
					res0.data   = partial_q + {4'd0, hv};
					n_res       = 2'd1;
					mode_nxt    = MODE_NORMAL;
					partial_nxt = 8'd0;
				end
				MODE_OCT2: begin
					partial_nxt = partial_q + {w[4:0], 3'd0};
					mode_nxt    = MODE_OCT3;
				end
				MODE_OCT3: begin
					res0.data   = partial_q + w;
					n_res       = 2'd1;
					mode_nxt    = MODE_NORMAL;
					partial_nxt = 8'd0;
				end
				default: begin
					mode_nxt = MODE_NORMAL;
					if (char_s1 == CH_QUOTE) begin
						partial_nxt = 8'd0;
						n_res       = 2'd1;
						res0        = '{kind: KIND_DONE, data: 8'd0, last: 1'b1};
					end else if (char_s1 == CH_BSL) begin
						mode_nxt = MODE_ESC;
					end else begin
						n_res = 2'd1;
					end
				end
			endcase
		end
	end

	// The decoded item moves on only if the buffer has room for its results.
	assign pop      = result_valid && !result_stall;
	assign base_cnt = count_q - {1'b0, pop};
	assign fire_s1  = valid_s1 && (({1'b0, base_cnt} + {1'b0, n_res}) <= 3'd2);

	// Decode state advances once per item taken from the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_NORMAL;
			partial_q <= 8'd0;
		end else if (fire_s1) begin
			mode_q    <= mode_nxt;
			partial_q <= partial_nxt;
		end
	end

	// Result buffer: shift out on pop, then append the new results behind.
	always_comb begin
		entry_nxt[0] = entry_q[0];
		entry_nxt[1] = entry_q[1];
		if (pop) begin
			entry_nxt[0] = entry_q[1];
		end
		count_nxt = base_cnt;
		if (fire_s1) begin
			if (n_res != 2'd0) begin
				if (base_cnt == 2'd0) begin
					entry_nxt[0] = res0;
				end else begin
					entry_nxt[1] = res0;
				end
			end
			if (n_res == 2'd2) begin
				entry_nxt[1] = res1;
			end
			count_nxt = base_cnt + n_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		entry_q[0] <= entry_nxt[0];
		entry_q[1] <= entry_nxt[1];
	end

	// Result port
	assign result_valid = (count_q != 2'd0);
	assign result_kind  = entry_q[0].kind;
	assign out_byte     = entry_q[0].data;
	assign last_of_run  = entry_q[0].last;

	// The buffer never holds more than two results.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2)
		else $error("result buffer overfilled");

	// With two results buffered, the rear one always ends its character's run.
	a_pair_rear: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == 2'd2 |-> entry_q[1].last)
		else $error("two buffered results but rear one does not end a run");

	// Only the defined decode modes are ever reached.
	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q <= MODE_OCT3)
		else $error("decode mode out of range");

	// End of line always returns the decoder to normal text.
	a_nul_reset: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && char_s1 == CH_NUL |=> mode_q == MODE_NORMAL && partial_q == 8'd0)
		else $error("end of line did not clear decode state");

	// Done and unterminated results carry a zero byte.
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_kind != KIND_BYTE |-> out_byte == 8'd0 && last_of_run)
		else $error("status result with nonzero byte");

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for string_literal_escape_decoder: feeds literal bodies
// one character per item and checks every decoded byte, close and error result.
// Depends on sled_pkg and the decoder RTL; needs no other file.

module tb;
	import sled_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned OPENING_LEN  = 25;
	localparam int unsigned RANDOM_CHARS = 1150;
	localparam int unsigned PAUSE_EVERY  = 400;
	localparam int unsigned DRAIN_CYCLES = 8;

	// Control codes produced by the single-letter escapes
	localparam logic [7:0] CTL_BEL = 8'h07;
	localparam logic [7:0] CTL_BS  = 8'h08;
	localparam logic [7:0] CTL_HT  = 8'h09;
	localparam logic [7:0] CTL_LF  = 8'h0A;
	localparam logic [7:0] CTL_VT  = 8'h0B;
	localparam logic [7:0] CTL_FF  = 8'h0C;
	localparam logic [7:0] CTL_CR  = 8'h0D;
	// A letter that is not a known escape
	localparam logic [7:0] CH_LQ   = 8'h71;

	typedef struct {
		logic       pause;
		logic [7:0] ch;
	} feed_t;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       char_valid   = 1'b0;
	logic       char_stall;
	logic [7:0] char_in      = 8'h00;
	logic       result_valid;
	logic       result_stall = 1'b0;
	logic [1:0] result_kind;
	logic [7:0] out_byte;
	logic       last_of_run;

	feed_t   char_feed[$];
	result_t pending_results[$];

	// Decoder state as the checker sees it
	logic [MODE_W-1:0] esc_mode  = MODE_NORMAL;
	logic [7:0]        acc_value = 8'h00;

	int chars_total;
	int chars_issued;
	int chars_taken;
	int results_seen;
	int done_count;
	int unterm_count;
	int pair_count;
	int fail_count;
	int cycle_count;
	int gap_left;
	int stall_left;
	bit feed_calm;
	bit sink_calm;

	// Directed opening: plain extremes, escapes, octal overflow, an unknown
	// escape, a close, a quote and an end of line inside a hex escape.
	logic [7:0] opening [OPENING_LEN] = '{
		CH_UA, 8'hFF, 8'h01, CH_BSL, CH_LN,
		CH_BSL, CH_LX, CH_LF, CH_UF,
		CH_BSL, CH_NINE, CH_NINE, CH_NINE,
		CH_BSL, CH_LQ, CH_QUOTE,
		CH_BSL, CH_LX, CH_QUOTE, CH_NUL, CH_NUL,
		CH_BSL, CH_BSL, CH_BSL, CH_QUOTE
	};

	string_literal_escape_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.char_in      (char_in),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_kind  (result_kind),
		.out_byte     (out_byte),
		.last_of_run  (last_of_run)
	);

	always #5 clk = ~clk;

	// Run limit, far above the slowest correct run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timed out with %0d results still expected.", pending_results.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic void add_result(input logic [1:0] kind, input logic [7:0] data,
			input logic last);
		result_t r;
		r.kind = kind;
		r.data = data;
		r.last = last;
		pending_results.insert(pending_results.size(), r);
	endfunction

	// Value of a hex digit; any other character weighs nothing.
	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE) return 4'(c - CH_ZERO);
		if (c >= CH_LA && c <= CH_LF) return 4'(c - CH_LA + 8'd10);
		if (c >= CH_UA && c <= CH_UF) return 4'(c - CH_UA + 8'd10);
		return 4'd0;
	endfunction

	// Works out the results of one accepted character and advances the state.
	function automatic void decode_char(input logic [7:0] c);
		logic [7:0] w;
		w = c - CH_ZERO;
		if (c == CH_NUL) begin
			esc_mode  = MODE_NORMAL;
			acc_value = 8'h00;
			add_result(KIND_UNTERM, 8'h00, 1'b1);
			unterm_count++;
		end else begin
			case (esc_mode)
				MODE_ESC: begin
					esc_mode = MODE_NORMAL;
					case (c)
						CH_QUOTE: add_result(KIND_BYTE, CH_QUOTE, 1'b1);
						CH_BSL:   add_result(KIND_BYTE, CH_BSL, 1'b1);
						CH_LA:    add_result(KIND_BYTE, CTL_BEL, 1'b1);
						CH_LB:    add_result(KIND_BYTE, CTL_BS, 1'b1);
						CH_LT:    add_result(KIND_BYTE, CTL_HT, 1'b1);
						CH_LN:    add_result(KIND_BYTE, CTL_LF, 1'b1);
						CH_LV:    add_result(KIND_BYTE, CTL_VT, 1'b1);
						CH_LF:    add_result(KIND_BYTE, CTL_FF, 1'b1);
						CH_LR:    add_result(KIND_BYTE, CTL_CR, 1'b1);
						CH_LX: begin
							esc_mode  = MODE_HEX1;
							acc_value = 8'h00;
						end
						default: begin
							if (c >= CH_ZERO && c <= CH_NINE) begin
								acc_value = w << 6;
								esc_mode  = MODE_OCT2;
							end else begin
								// Unknown escape keeps the backslash as text.
								add_result(KIND_BYTE, CH_BSL, 1'b0);
								add_result(KIND_BYTE, c, 1'b1);
								pair_count++;
							end
						end
					endcase
				end
				MODE_HEX1: begin
					acc_value = {hex_nibble(c), 4'h0};
					esc_mode  = MODE_HEX2;
				end
				MODE_HEX2: begin
					add_result(KIND_BYTE, acc_value + hex_nibble(c), 1'b1);
					esc_mode  = MODE_NORMAL;
					acc_value = 8'h00;
				end
				MODE_OCT2: begin
					acc_value = acc_value + (w << 3);
					esc_mode  = MODE_OCT3;
				end
				MODE_OCT3: begin
					add_result(KIND_BYTE, acc_value + w, 1'b1);
					esc_mode  = MODE_NORMAL;
					acc_value = 8'h00;
				end
				default: begin
					esc_mode = MODE_NORMAL;
					if (c == CH_QUOTE) begin
						acc_value = 8'h00;
						add_result(KIND_DONE, 8'h00, 1'b1);
						done_count++;
					end else if (c == CH_BSL) begin
						esc_mode = MODE_ESC;
					end else begin
						add_result(KIND_BYTE, c, 1'b1);
					end
				end
			endcase
		end
	endfunction

	function automatic void add_char(input logic [7:0] c);
		feed_t f;
		f.pause = 1'b0;
		f.ch    = c;
		char_feed.insert(char_feed.size(), f);
		chars_total++;
	endfunction

	// Marks a point where the sender holds off until every result is out.
	function automatic void add_pause();
		feed_t f;
		f.pause = 1'b1;
		f.ch    = CH_NUL;
		char_feed.insert(char_feed.size(), f);
	endfunction

	// Mostly a proper digit for the escape, now and then an arbitrary byte.
	function automatic logic [7:0] escape_digit(input bit hex);
		int r;
		r = $urandom_range(0, 24);
		if (r >= 22) return 8'($urandom_range(1, 255));
		if (!hex) return 8'(CH_ZERO + r % 10);
		if (r < 10) return 8'(CH_ZERO + r);
		if (r < 16) return 8'(CH_LA + r - 10);
		return 8'(CH_UA + r - 16);
	endfunction

	// Appends one random piece of literal text: plain text, an escape, a close,
	// an end of line, a broken escape or raw noise.
	task automatic add_fragment();
		int pick;
		logic [7:0] c;
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			c = 8'($urandom_range(1, 255));
			if (c == CH_QUOTE || c == CH_BSL) c = CH_UA;
			add_char(c);
		end else if (pick < 50) begin
			add_char(CH_BSL);
			case ($urandom_range(0, 8))
				0: c = CH_QUOTE;
				1: c = CH_BSL;
				2: c = CH_LA;
				3: c = CH_LB;
				4: c = CH_LT;
				5: c = CH_LN;
				6: c = CH_LV;
				7: c = CH_LF;
				default: c = CH_LR;
			endcase
			add_char(c);
		end else if (pick < 60) begin
			add_char(CH_BSL);
			add_char(CH_LX);
			add_char(escape_digit(1'b1));
			add_char(escape_digit(1'b1));
		end else if (pick < 70) begin
			add_char(CH_BSL);
			add_char(8'(CH_ZERO + $urandom_range(0, 9)));
			add_char(escape_digit(1'b0));
			add_char(escape_digit(1'b0));
		end else if (pick < 78) begin
			add_char(CH_BSL);
			add_char(8'($urandom_range(1, 255)));
		end else if (pick < 86) begin
			add_char(CH_QUOTE);
		end else if (pick < 90) begin
			add_char(CH_NUL);
		end else if (pick < 95) begin
			// Escape cut short by an end of line.
			add_char(CH_BSL);
			case ($urandom_range(0, 3))
				1: add_char(CH_LX);
				2: begin
					add_char(CH_LX);
					add_char(escape_digit(1'b1));
				end
				3: begin
					add_char(8'(CH_ZERO + $urandom_range(0, 9)));
					add_char(escape_digit(1'b0));
				end
				default: ;
			endcase
			add_char(CH_NUL);
		end else begin
			add_char(8'($urandom_range(0, 255)));
		end
	endtask

	// Sender: presents the next item after a random gap and holds it until taken.
	always @(negedge clk) begin
		if (arst_n) begin
			if (char_valid && chars_taken != chars_issued) begin
				// Item not yet taken; payload stays put.
			end else if (gap_left > 0) begin
				char_valid <= 1'b0;
				gap_left--;
			end else if (char_feed.size() != 0 && char_feed[0].pause) begin
				char_valid <= 1'b0;
				if (pending_results.size() == 0) void'(char_feed.pop_front());
			end else if (char_feed.size() != 0) begin
				char_in    <= char_feed[0].ch;
				char_valid <= 1'b1;
				void'(char_feed.pop_front());
				chars_issued++;
				if ($urandom_range(0, 49) == 0) feed_calm = !feed_calm;
				gap_left = feed_calm ? 0 : $urandom_range(0, 7);
			end else begin
				char_valid <= 1'b0;
			end
		end
	end

	// Receiver: stalls for a random number of cycles after each result.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			result_stall <= 1'b1;
			stall_left--;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// Monitor: checks each result against the oldest expectation, then predicts
	// the results of any character taken at this edge.
	always @(posedge clk) begin : monitor
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if ($urandom_range(0, 49) == 0) sink_calm = !sink_calm;
			stall_left = sink_calm ? 0 : $urandom_range(0, 7);
			if (pending_results.size() == 0) begin
				$error("Unexpected result: result_kind %0d out_byte %02h last_of_run %0d",
					result_kind, out_byte, last_of_run);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (result_kind !== want.kind) begin
					$error("result_kind: expected %0d, got %0d", want.kind, result_kind);
					fail_count++;
				end
				if (out_byte !== want.data) begin
					$error("out_byte: expected %02h, got %02h", want.data, out_byte);
					fail_count++;
				end
				if (last_of_run !== want.last) begin
					$error("last_of_run: expected %0d, got %0d", want.last, last_of_run);
					fail_count++;
				end
			end
		end
		if (arst_n && char_valid && !char_stall) begin
			decode_char(char_in);
			chars_taken++;
		end
	end

	// Builds the stimulus, releases reset and decides the verdict.
	initial begin : stimulus
		int next_pause;
		foreach (opening[i]) add_char(opening[i]);
		add_pause();
		next_pause = chars_total + PAUSE_EVERY;
		while (chars_total < OPENING_LEN + RANDOM_CHARS) begin
			add_fragment();
			if (chars_total >= next_pause) begin
				add_pause();
				next_pause += PAUSE_EVERY;
			end
		end

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		while (chars_taken != chars_total || pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			fail_count++;
		end
		$display("Fed %0d characters and checked %0d results in %0d cycles.",
			chars_taken, results_seen, cycle_count);
		$display("Seen %0d closed strings, %0d unterminated lines, %0d unknown escapes.",
			done_count, unterm_count, pair_count);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

### string_literal_escape_decoder.f
hw/rtl/sled_pkg.sv
hw/rtl/string_literal_escape_decoder.sv
verif/tb.sv
